>>> hdl/vas_pkg.sv
// Shared types, constants and helpers for the visual alignment supervisor.
`default_nettype none

package vas_pkg;

    // Pixel coordinate width used for error arithmetic
    localparam int COORD_BITS = 12;
    localparam int ERR_W      = COORD_BITS + 1;

    // Q8 scale factors and axis signs
    localparam int MM_PER_PX_Q8  = 64;
    localparam int DEG_PER_PX_Q8 = 64;
    localparam int X_SIGN        = 1;
    localparam int Y_SIGN        = 1;
    localparam int Z_SIGN        = 1;

    localparam int SCALE_W = 12;
    localparam logic signed [SCALE_W-1:0] X_SCALE = SCALE_W'(MM_PER_PX_Q8 * X_SIGN);
    localparam logic signed [SCALE_W-1:0] Y_SCALE = SCALE_W'(MM_PER_PX_Q8 * Y_SIGN);
    localparam logic signed [SCALE_W-1:0] Z_SCALE = SCALE_W'(DEG_PER_PX_Q8 * Z_SIGN);

    // Multiplier operand and product widths
    localparam int ROT_W  = 12;
    localparam int OPW    = (ERR_W > ROT_W) ? ERR_W : ROT_W;
    localparam int PROD_W = OPW + SCALE_W;

    localparam int AMOUNT_W = 23;
    localparam logic signed [PROD_W-1:0] AMOUNT_MAX = PROD_W'((64'sd1 <<< (AMOUNT_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] AMOUNT_MIN = PROD_W'(-(64'sd1 <<< (AMOUNT_W - 1)));

    // Stream widths
    localparam int IN_FIELDS_W  = 78;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 68;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Job queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_MEASURE = 2'd1,
        CMD_TICK    = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_TRAY  = 2'd0,
        MODE_CALIB = 2'd1,
        MODE_RING  = 2'd2
    } task_code_t;

    typedef enum logic [1:0] {
        KIND_REQUEST   = 2'd0,
        KIND_ROTATE    = 2'd1,
        KIND_TRANSLATE = 2'd2,
        KIND_FINISHED  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_ALIGNED   = 2'd0,
        ST_TIMEOUT   = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_DIVERGED  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        CFG_TRAY_X    = 3'd0,
        CFG_TRAY_Y    = 3'd1,
        CFG_CALIB_X   = 3'd2,
        CFG_CALIB_Y   = 3'd3,
        CFG_TOL_PX    = 3'd4,
        CFG_Z_TOL     = 3'd5,
        CFG_MAX_ROUND = 3'd6,
        CFG_TIMEOUT   = 3'd7
    } cfg_index_t;

    // One input item
    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         task_mode;
        logic [7:0]         ring_code;
        logic [15:0]        speed_limit;
        logic [15:0]        step_period;
        logic [11:0]        meas_x;
        logic [11:0]        meas_y;
        logic signed [11:0] meas_z;
    } in_item_t;

    // Work handed from front to back: optional moves, then one closing result
    typedef struct packed {
        logic [1:0]              task_id;
        logic [7:0]              color;
        logic [15:0]             speed;
        logic [15:0]             period;
        logic signed [ERR_W-1:0] ex;
        logic signed [ERR_W-1:0] ey;
        logic signed [ROT_W-1:0] ez;
        logic                    do_rot;
        logic                    do_x;
        logic                    do_y;
        logic                    tail_finish;
        logic [1:0]              status;
    } job_t;

    // One result item
    typedef struct packed {
        logic [1:0]                 kind;
        logic [1:0]                 task_id;
        logic [7:0]                 color;
        logic signed [AMOUNT_W-1:0] amount;
        logic                       axis;
        logic [15:0]                speed_out;
        logic [15:0]                period_out;
        logic [1:0]                 status;
        logic                       last;
    } res_t;

    // Take a 12-bit pixel coordinate to COORD_BITS bits
    function automatic logic [COORD_BITS-1:0] coord_trunc(input logic [11:0] v);
        logic [COORD_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < COORD_BITS && i < 12; i++)
        begin
            r[i] = v[i];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hdl/vas_front.sv
// Front end: config registers, task state, and classification of each item into a job.
`default_nettype none

module vas_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire vas_pkg::in_item_t in_item,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output vas_pkg::job_t          push_job
);

    localparam int EW = vas_pkg::ERR_W;
    localparam int CB = vas_pkg::COORD_BITS;

    // Configuration registers
    logic [11:0] tray_x_reg, tray_y_reg, calib_x_reg, calib_y_reg;
    logic [7:0]  tol_px_reg, z_tol_reg, max_rounds_reg;
    logic [15:0] timeout_reg;

    // Task state
    logic [1:0]    task_reg, task_next;
    logic          waiting_reg, waiting_next;
    logic [7:0]    color_reg, color_next;
    logic [15:0]   speed_reg, speed_next;
    logic [15:0]   period_reg, period_next;
    logic [7:0]    round_reg, round_next;
    logic [15:0]   tick_reg, tick_next;
    logic [EW-1:0] prev_x_reg, prev_x_next;
    logic [EW-1:0] prev_y_reg, prev_y_next;
    logic [11:0]   prev_z_reg, prev_z_next;

    logic accept;

    // Measurement arithmetic
    logic                 calib;
    logic [CB-1:0]        tx, ty, mx, my;
    logic signed [EW-1:0] ex, ey;
    logic [EW-1:0]        ax, ay;
    logic signed [12:0]   ez_wide;
    logic [12:0]          az_wide;
    logic [11:0]          az;
    logic                 xin, yin, zin, diverge;
    logic [7:0]           round_inc;
    logic [15:0]          tick_inc;

    assign accept   = in_valid && push_ready;
    assign in_ready = push_ready;

    assign calib = (task_reg == vas_pkg::MODE_CALIB);
    assign tx = vas_pkg::coord_trunc(calib ? calib_x_reg : tray_x_reg);
    assign ty = vas_pkg::coord_trunc(calib ? calib_y_reg : tray_y_reg);
    assign mx = vas_pkg::coord_trunc(in_item.meas_x);
    assign my = vas_pkg::coord_trunc(in_item.meas_y);
    assign ex = $signed({1'b0, tx}) - $signed({1'b0, mx});
    assign ey = $signed({1'b0, ty}) - $signed({1'b0, my});
    assign ax = ex[EW-1] ? EW'(-ex) : EW'(ex);
    assign ay = ey[EW-1] ? EW'(-ey) : EW'(ey);
    assign ez_wide = 13'(in_item.meas_z);
    assign az_wide = ez_wide[12] ? 13'(-ez_wide) : 13'(ez_wide);
    assign az = calib ? az_wide[11:0] : 12'd0;

    assign xin = (ax <= EW'(tol_px_reg));
    assign yin = (ay <= EW'(tol_px_reg));
    assign zin = !calib || (az <= 12'(z_tol_reg));
    assign diverge = (round_reg != 8'd0) &&
                     (({1'b0, ax} > {prev_x_reg, 1'b0}) ||
                      ({1'b0, ay} > {prev_y_reg, 1'b0}) ||
                      (calib && ({1'b0, az} > {prev_z_reg, 1'b0})));

    assign round_inc = (round_reg == 8'hFF) ? round_reg : round_reg + 8'd1;
    assign tick_inc  = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;

    // Next state and job build
    always_comb
    begin
        task_next   = task_reg;
        waiting_next = waiting_reg;
        color_next  = color_reg;
        speed_next  = speed_reg;
        period_next = period_reg;
        round_next  = round_reg;
        tick_next   = tick_reg;
        prev_x_next = prev_x_reg;
        prev_y_next = prev_y_reg;
        prev_z_next = prev_z_reg;

        push_valid           = 1'b0;
        push_job.task_id     = task_reg;
        push_job.color       = 8'd0;
        push_job.speed       = speed_reg;
        push_job.period      = period_reg;
        push_job.ex          = ex;
        push_job.ey          = ey;
        push_job.ez          = in_item.meas_z;
        push_job.do_rot      = 1'b0;
        push_job.do_x        = 1'b0;
        push_job.do_y        = 1'b0;
        push_job.tail_finish = 1'b0;
        push_job.status      = vas_pkg::ST_ALIGNED;

        if (accept)
        begin
            // unknown command falls through all arms and is ignored
            if (in_item.command == vas_pkg::CMD_START)
            begin
                if (in_item.task_mode != 2'd3)
                begin
                    task_next    = in_item.task_mode;
                    color_next   = in_item.ring_code;
                    speed_next   = in_item.speed_limit;
                    period_next  = in_item.step_period;
                    round_next   = 8'd0;
                    tick_next    = 16'd0;
                    prev_x_next  = '0;
                    prev_y_next  = '0;
                    prev_z_next  = '0;
                    push_valid   = 1'b1;
                    push_job.task_id = in_item.task_mode;
                    push_job.speed   = in_item.speed_limit;
                    push_job.period  = in_item.step_period;
                    if (max_rounds_reg == 8'd0)
                    begin
                        waiting_next         = 1'b0;
                        push_job.tail_finish = 1'b1;
                        push_job.status      = vas_pkg::ST_EXHAUSTED;
                    end
                    else
                    begin
                        waiting_next = 1'b1;
                        if (in_item.task_mode == vas_pkg::MODE_RING)
                        begin
                            push_job.color = in_item.ring_code;
                        end
                    end
                end
            end
            else if (in_item.command == vas_pkg::CMD_MEASURE)
            begin
                if (waiting_reg)
                begin
                    push_valid = 1'b1;
                    if (xin && yin && zin)
                    begin
                        waiting_next         = 1'b0;
                        push_job.tail_finish = 1'b1;
                        push_job.status      = vas_pkg::ST_ALIGNED;
                    end
                    else if (diverge)
                    begin
                        waiting_next         = 1'b0;
                        push_job.tail_finish = 1'b1;
                        push_job.status      = vas_pkg::ST_DIVERGED;
                    end
                    else
                    begin
                        prev_x_next = ax;
                        prev_y_next = ay;
                        if (calib)
                        begin
                            prev_z_next = az;
                        end
                        push_job.do_rot = !zin;
                        push_job.do_x   = !xin;
                        push_job.do_y   = !yin;
                        round_next      = round_inc;
                        if (round_inc >= max_rounds_reg)
                        begin
                            waiting_next         = 1'b0;
                            push_job.tail_finish = 1'b1;
                            push_job.status      = vas_pkg::ST_EXHAUSTED;
                        end
                        else
                        begin
                            tick_next = 16'd0;
                            if (task_reg == vas_pkg::MODE_RING)
                            begin
                                push_job.color = color_reg;
                            end
                        end
                    end
                end
            end
            else if (in_item.command == vas_pkg::CMD_TICK)
            begin
                if (waiting_reg)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= timeout_reg)
                    begin
                        waiting_next         = 1'b0;
                        push_valid           = 1'b1;
                        push_job.tail_finish = 1'b1;
                        push_job.status      = vas_pkg::ST_TIMEOUT;
                    end
                end
            end
        end
    end

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tray_x_reg     <= 12'd320;
            tray_y_reg     <= 12'd240;
            calib_x_reg    <= 12'd320;
            calib_y_reg    <= 12'd240;
            tol_px_reg     <= 8'd5;
            z_tol_reg      <= 8'd5;
            max_rounds_reg <= 8'd10;
            timeout_reg    <= 16'd3000;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                vas_pkg::CFG_TRAY_X:    tray_x_reg     <= cfg_data[11:0];
                vas_pkg::CFG_TRAY_Y:    tray_y_reg     <= cfg_data[11:0];
                vas_pkg::CFG_CALIB_X:   calib_x_reg    <= cfg_data[11:0];
                vas_pkg::CFG_CALIB_Y:   calib_y_reg    <= cfg_data[11:0];
                vas_pkg::CFG_TOL_PX:    tol_px_reg     <= cfg_data[7:0];
                vas_pkg::CFG_Z_TOL:     z_tol_reg      <= cfg_data[7:0];
                vas_pkg::CFG_MAX_ROUND: max_rounds_reg <= cfg_data[7:0];
                vas_pkg::CFG_TIMEOUT:   timeout_reg    <= cfg_data;
                default:                timeout_reg    <= timeout_reg;
            endcase
        end
    end

    // Task state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_reg    <= 2'd0;
            waiting_reg <= 1'b0;
            color_reg   <= 8'd0;
            speed_reg   <= 16'd0;
            period_reg  <= 16'd0;
            round_reg   <= 8'd0;
            tick_reg    <= 16'd0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
            prev_z_reg  <= '0;
        end
        else
        begin
            task_reg    <= task_next;
            waiting_reg <= waiting_next;
            color_reg   <= color_next;
            speed_reg   <= speed_next;
            period_reg  <= period_next;
            round_reg   <= round_next;
            tick_reg    <= tick_next;
            prev_x_reg  <= prev_x_next;
            prev_y_reg  <= prev_y_next;
            prev_z_reg  <= prev_z_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/vas_queue.sv
// Short job queue between the front end and the result sequencer.
`default_nettype none

module vas_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output logic               push_ready,
    input  wire vas_pkg::job_t push_job,
    output logic               pop_valid,
    input  wire logic          pop_ready,
    output vas_pkg::job_t      pop_job
);

    localparam int PW = vas_pkg::QPTR_W;
    localparam int CW = vas_pkg::QCNT_W;

    vas_pkg::job_t entry_reg [vas_pkg::QDEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign push_ready = (count_reg != CW'(vas_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(vas_pkg::QDEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(vas_pkg::QDEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> hdl/vas_back.sv
// Result sequencer: turns one job into its moves and closing item, one per cycle while the output is taken.
`default_nettype none

module vas_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire vas_pkg::job_t pop_job,
    output logic               out_valid,
    input  wire logic          out_ready,
    output vas_pkg::res_t      out_res
);

    localparam int OW = vas_pkg::OPW;
    localparam int PW = vas_pkg::PROD_W;
    localparam int AW = vas_pkg::AMOUNT_W;

    vas_pkg::job_t cur_reg, cur_next;
    logic          cur_valid_reg, cur_valid_next;
    vas_pkg::res_t out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic                                out_free, emit, is_tail;
    logic signed [OW-1:0]                op;
    logic signed [vas_pkg::SCALE_W-1:0]  scl;
    logic signed [PW-1:0]                prod;
    logic signed [AW-1:0]                amt;

    assign out_free  = !out_valid_reg || out_ready;
    assign emit      = cur_valid_reg && out_free;
    assign is_tail   = !cur_reg.do_rot && !cur_reg.do_x && !cur_reg.do_y;
    assign pop_ready = !cur_valid_reg || (emit && is_tail);

    // Pick the pending move: rotation first, then x, then y
    always_comb
    begin
        priority if (cur_reg.do_rot)
        begin
            op  = OW'(cur_reg.ez);
            scl = vas_pkg::Z_SCALE;
        end
        else if (cur_reg.do_x)
        begin
            op  = OW'(cur_reg.ex);
            scl = vas_pkg::X_SCALE;
        end
        else
        begin
            op  = OW'(cur_reg.ey);
            scl = vas_pkg::Y_SCALE;
        end
    end

    // Scale to Q8 and saturate
    assign prod = op * scl;
    assign amt  = (prod > vas_pkg::AMOUNT_MAX) ? vas_pkg::AMOUNT_MAX[AW-1:0] :
                  (prod < vas_pkg::AMOUNT_MIN) ? vas_pkg::AMOUNT_MIN[AW-1:0] :
                  prod[AW-1:0];

    // Build the next result item
    always_comb
    begin
        out_next.task_id    = cur_reg.task_id;
        out_next.color      = 8'd0;
        out_next.amount     = amt;
        out_next.axis       = 1'b0;
        out_next.speed_out  = cur_reg.speed;
        out_next.period_out = cur_reg.period;
        out_next.status     = vas_pkg::ST_ALIGNED;
        out_next.last       = 1'b0;
        out_next.kind       = vas_pkg::KIND_TRANSLATE;
        priority if (cur_reg.do_rot)
        begin
            out_next.kind = vas_pkg::KIND_ROTATE;
        end
        else if (cur_reg.do_x)
        begin
            out_next.kind = vas_pkg::KIND_TRANSLATE;
        end
        else if (cur_reg.do_y)
        begin
            out_next.axis = 1'b1;
        end
        else
        begin
            out_next.kind       = cur_reg.tail_finish ? vas_pkg::KIND_FINISHED
                                                      : vas_pkg::KIND_REQUEST;
            out_next.color      = cur_reg.tail_finish ? 8'd0 : cur_reg.color;
            out_next.status     = cur_reg.tail_finish ? cur_reg.status : vas_pkg::ST_ALIGNED;
            out_next.amount     = '0;
            out_next.speed_out  = 16'd0;
            out_next.period_out = 16'd0;
            out_next.last       = 1'b1;
        end
    end

    // Job register: load a new job or retire the move just sent
    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        if (pop_ready)
        begin
            cur_valid_next = pop_valid;
            cur_next       = pop_job;
        end
        else if (emit)
        begin
            priority if (cur_reg.do_rot)
            begin
                cur_next.do_rot = 1'b0;
            end
            else if (cur_reg.do_x)
            begin
                cur_next.do_x = 1'b0;
            end
            else
            begin
                cur_next.do_y = 1'b0;
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (emit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule

`default_nettype wire

>>> hdl/visual_alignment_supervisor.sv
// Top level of the visual alignment supervisor: stream ports, front, queue and back.
//
// A start item answers with one result (a vision request, or "rounds exhausted"
// when max_rounds is zero); a measurement answers with one to four results
// (rotate, x move, y move, then a request or a finish); a tick answers with a
// timeout finish or nothing. The front end classifies an item in the cycle it is
// accepted and can take a new item every cycle while the two-entry job queue
// has room; the back end sends one result per cycle while the output is taken,
// so a measurement with all three corrections sends four results. The first
// result passes the queue, job and output registers. Configuration is written
// through cfg_valid/cfg_index/cfg_data and is always ready.
`default_nettype none

module visual_alignment_supervisor (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [2:0]                      cfg_index,
    input  wire logic [15:0]                     cfg_data,
    // input items
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // task_mode[1:0], ring_code[9:2], speed_limit[25:10], step_period[41:26],
    // meas_x[53:42], meas_y[65:54], meas_z[77:66], zero fill
    input  wire logic [vas_pkg::IN_TDATA_W-1:0]  s_tdata,
    // command[1:0]
    input  wire logic [1:0]                      s_tuser,
    // result items
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // task_res[1:0], color[9:2], amount[32:10], axis[33], speed_out[49:34],
    // period_out[65:50], status[67:66], zero fill
    output logic [vas_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // kind[1:0]
    output logic [1:0]                           m_tuser,
    output logic                                 m_tlast
);

    vas_pkg::in_item_t in_item;
    vas_pkg::job_t     push_job, pop_job;
    vas_pkg::res_t     res;
    logic              push_valid, push_ready, pop_valid, pop_ready;

    assign cfg_ready = 1'b1;

    // Unpack the input item
    assign in_item.command     = s_tuser;
    assign in_item.task_mode   = s_tdata[1:0];
    assign in_item.ring_code   = s_tdata[9:2];
    assign in_item.speed_limit = s_tdata[25:10];
    assign in_item.step_period = s_tdata[41:26];
    assign in_item.meas_x      = s_tdata[53:42];
    assign in_item.meas_y      = s_tdata[65:54];
    assign in_item.meas_z      = s_tdata[77:66];

    vas_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    vas_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    vas_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // Pack the result item
    assign m_tdata = {{(vas_pkg::OUT_TDATA_W - vas_pkg::OUT_FIELDS_W){1'b0}},
                      res.status, res.period_out, res.speed_out, res.axis,
                      res.amount, res.color, res.task_id};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

    // A move is always followed by more items of the same answer
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("non-final result not followed by another");

    // Requests and finishes close an answer; moves never do
    a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == vas_pkg::KIND_REQUEST || m_tuser == vas_pkg::KIND_FINISHED)
        |-> m_tlast)
        else $error("request or finish without last");

    a_move_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == vas_pkg::KIND_ROTATE || m_tuser == vas_pkg::KIND_TRANSLATE)
        |-> !m_tlast && res.status == vas_pkg::ST_ALIGNED && res.color == 8'd0)
        else $error("move carries last, status or color");

endmodule

`default_nettype wire

>>> test/alignment_result_checker.sv
// Checker for the visual alignment supervisor: predicts result items and compares them.
module alignment_result_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [2:0]                     cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // task_mode, ring_code, speed_limit, step_period, meas_x, meas_y, meas_z
    input  logic [vas_pkg::IN_TDATA_W-1:0]  s_tdata,
    // command
    input  logic [1:0]                     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    // task_res, color, amount, axis, speed_out, period_out, status
    input  logic [vas_pkg::OUT_TDATA_W-1:0] m_tdata,
    // kind
    input  logic [1:0]                     m_tuser,
    input  logic                           m_tlast,
    output int                             mismatch_count,
    output int                             results_due
);
    timeunit 1ns;
    timeprecision 1ps;

    import vas_pkg::*;

    localparam longint AMT_HI = (longint'(1) <<< (AMOUNT_W - 1)) - 1;
    localparam longint AMT_LO = -(longint'(1) <<< (AMOUNT_W - 1));
    // status field reads zero on every kind but finished
    localparam status_t NO_STATUS = ST_ALIGNED;

    // register copies
    logic [11:0] tray_tgt_x, tray_tgt_y, calib_tgt_x, calib_tgt_y;
    logic [7:0]  tol_px, tol_z, round_limit;
    logic [15:0] tick_limit;

    // supervisor state copy
    task_code_t  task_now;
    bit          waiting_meas;
    logic [7:0]  color_now;
    logic [15:0] speed_now, period_now;
    logic [7:0]  rounds_done;
    logic [15:0] ticks_waited;
    logic [12:0] prev_ax, prev_ay;
    logic [11:0] prev_az;

    // results still owed by the block, oldest first
    res_t expected_results[$];
    res_t held_result;
    bit   have_held;
    int   fails;

    function automatic res_t make_result(kind_t kind, logic [7:0] color, longint amount,
                                         logic axis, bit moving, status_t st);
        res_t r;
        if (amount > AMT_HI)
            amount = AMT_HI;
        if (amount < AMT_LO)
            amount = AMT_LO;
        r.kind       = kind;
        r.task_id    = task_now;
        r.color      = color;
        r.amount     = amount[AMOUNT_W-1:0];
        r.axis       = axis;
        r.speed_out  = moving ? speed_now : 16'd0;
        r.period_out = moving ? period_now : 16'd0;
        r.status     = st;
        r.last       = 1'b0;
        return r;
    endfunction

    function automatic string describe(res_t r);
        return $sformatf({"kind=%0d task=%0d color=%0d amount=%0d axis=%0d ",
                          "speed=%0d period=%0d status=%0d last=%0d"},
                         r.kind, r.task_id, r.color, r.amount, r.axis, r.speed_out,
                         r.period_out, r.status, r.last);
    endfunction

    // hold back one result so the final one of an item can get its last flag
    task automatic emit(res_t r);
        if (have_held)
            expected_results.push_back(held_result);
        held_result = r;
        have_held   = 1'b1;
    endtask

    task automatic finish_task(status_t st);
        emit(make_result(KIND_FINISHED, 8'd0, 0, 1'b0, 1'b0, st));
        waiting_meas = 1'b0;
    endtask

    task automatic issue_request();
        emit(make_result(KIND_REQUEST, (task_now == MODE_RING) ? color_now : 8'd0,
                         0, 1'b0, 1'b0, NO_STATUS));
        ticks_waited = 16'd0;
    endtask

    // one accepted input item: update the state copy and queue its results
    task automatic advance_supervisor(input logic [1:0] cmd, input logic [IN_TDATA_W-1:0] d);
        int tx, ty, ex, ey, ez, ax, ay, az;
        bit calib, x_ok, y_ok, z_ok;
        case (cmd_t'(cmd))
            CMD_START:
            begin
                if (d[1:0] inside {MODE_TRAY, MODE_CALIB, MODE_RING})
                begin
                    task_now     = task_code_t'(d[1:0]);
                    color_now    = d[9:2];
                    speed_now    = d[25:10];
                    period_now   = d[41:26];
                    rounds_done  = 8'd0;
                    ticks_waited = 16'd0;
                    prev_ax      = '0;
                    prev_ay      = '0;
                    prev_az      = '0;
                    waiting_meas = 1'b1;
                    if (round_limit == 8'd0)
                        finish_task(ST_EXHAUSTED);
                    else
                        issue_request();
                end
            end
            CMD_MEASURE:
            begin
                if (waiting_meas)
                begin
                    calib = (task_now == MODE_CALIB);
                    tx = calib ? int'(calib_tgt_x) : int'(tray_tgt_x);
                    ty = calib ? int'(calib_tgt_y) : int'(tray_tgt_y);
                    ex = tx - int'(d[53:42]);
                    ey = ty - int'(d[65:54]);
                    ez = int'($signed(d[77:66]));
                    ax = (ex < 0) ? -ex : ex;
                    ay = (ey < 0) ? -ey : ey;
                    az = calib ? ((ez < 0) ? -ez : ez) : 0;
                    x_ok = ax <= int'(tol_px);
                    y_ok = ay <= int'(tol_px);
                    z_ok = !calib || az <= int'(tol_z);
                    if (x_ok && y_ok && z_ok)
                        finish_task(ST_ALIGNED);
                    else if (rounds_done != 8'd0 &&
                             (ax > 2 * int'(prev_ax) || ay > 2 * int'(prev_ay) ||
                              (calib && az > 2 * int'(prev_az))))
                        finish_task(ST_DIVERGED);
                    else
                    begin
                        prev_ax = 13'(ax);
                        prev_ay = 13'(ay);
                        if (calib)
                            prev_az = 12'(az);
                        // rotation first, then x, then y
                        if (!z_ok)
                            emit(make_result(KIND_ROTATE, 8'd0,
                                             longint'(ez) * DEG_PER_PX_Q8 * Z_SIGN,
                                             1'b0, 1'b1, NO_STATUS));
                        if (!x_ok)
                            emit(make_result(KIND_TRANSLATE, 8'd0,
                                             longint'(ex) * MM_PER_PX_Q8 * X_SIGN,
                                             1'b0, 1'b1, NO_STATUS));
                        if (!y_ok)
                            emit(make_result(KIND_TRANSLATE, 8'd0,
                                             longint'(ey) * MM_PER_PX_Q8 * Y_SIGN,
                                             1'b1, 1'b1, NO_STATUS));
                        if (rounds_done != 8'hFF)
                            rounds_done++;
                        if (rounds_done >= round_limit)
                            finish_task(ST_EXHAUSTED);
                        else
                            issue_request();
                    end
                end
            end
            CMD_TICK:
            begin
                if (waiting_meas)
                begin
                    if (ticks_waited != 16'hFFFF)
                        ticks_waited++;
                    if (ticks_waited >= tick_limit)
                        finish_task(ST_TIMEOUT);
                end
            end
            default:
            begin
            end
        endcase
        // close the item: its final result carries last
        if (have_held)
        begin
            held_result.last = 1'b1;
            expected_results.push_back(held_result);
            have_held = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t got, want;
        if (!rst_n)
        begin
            tray_tgt_x   = 12'd320;
            tray_tgt_y   = 12'd240;
            calib_tgt_x  = 12'd320;
            calib_tgt_y  = 12'd240;
            tol_px       = 8'd5;
            tol_z        = 8'd5;
            round_limit  = 8'd10;
            tick_limit   = 16'd3000;
            task_now     = MODE_TRAY;
            waiting_meas = 1'b0;
            color_now    = '0;
            speed_now    = '0;
            period_now   = '0;
            rounds_done  = '0;
            ticks_waited = '0;
            prev_ax      = '0;
            prev_ay      = '0;
            prev_az      = '0;
            have_held    = 1'b0;
            fails        = 0;
            expected_results.delete();
            mismatch_count <= 0;
            results_due    <= 0;
        end
        else
        begin
            // register write
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_TRAY_X:    tray_tgt_x  = cfg_data[11:0];
                    CFG_TRAY_Y:    tray_tgt_y  = cfg_data[11:0];
                    CFG_CALIB_X:   calib_tgt_x = cfg_data[11:0];
                    CFG_CALIB_Y:   calib_tgt_y = cfg_data[11:0];
                    CFG_TOL_PX:    tol_px      = cfg_data[7:0];
                    CFG_Z_TOL:     tol_z       = cfg_data[7:0];
                    CFG_MAX_ROUND: round_limit = cfg_data[7:0];
                    CFG_TIMEOUT:   tick_limit  = cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            if (s_tvalid && s_tready)
                advance_supervisor(s_tuser, s_tdata);

            // compare one result item with the oldest expectation
            if (m_tvalid && m_tready)
            begin
                got.kind       = m_tuser;
                got.task_id    = m_tdata[1:0];
                got.color      = m_tdata[9:2];
                got.amount     = m_tdata[32:10];
                got.axis       = m_tdata[33];
                got.speed_out  = m_tdata[49:34];
                got.period_out = m_tdata[65:50];
                got.status     = m_tdata[67:66];
                got.last       = m_tlast;
                if (expected_results.size() == 0)
                begin
                    fails++;
                    if (fails <= 10)
                        $display("unexpected result item: %s", describe(got));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        if (fails <= 10)
                            $display("mismatch: expected %s\n          actual   %s",
                                     describe(want), describe(got));
                    end
                end
            end

            mismatch_count <= fails;
            results_due    <= expected_results.size();
        end
    end

endmodule

>>> test/visual_alignment_supervisor_tb.sv
// Testbench top for the visual alignment supervisor: stimulus, back pressure and verdict.
module visual_alignment_supervisor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import vas_pkg::*;

    // codes the package leaves unnamed
    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam logic [1:0] TASK_UNUSED = 2'd3;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [2:0]             cfg_index = '0;
    logic [15:0]            cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;

    int mismatch_count;
    int results_due;
    int items_sent  = 0;
    int stall_left  = 0;
    bit steady_send = 1'b0;
    bit steady_recv = 1'b0;

    // targets as last written, to steer measurements
    int guide_tray_x  = 320;
    int guide_tray_y  = 240;
    int guide_calib_x = 320;
    int guide_calib_y = 240;

    visual_alignment_supervisor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    alignment_result_checker chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    always #1 clk = ~clk;

    // mostly short gaps, now and then a long one
    function automatic int gap_length();
        if ($urandom_range(0, 19) < 16)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_item(
        logic [1:0] mode, logic [7:0] color, logic [15:0] speed, logic [15:0] period,
        logic [11:0] mx, logic [11:0] my, logic [11:0] mz);
        return {2'b00, mz, my, mx, period, speed, color, mode};
    endfunction

    // every field random
    function automatic logic [IN_TDATA_W-1:0] random_item();
        return pack_item(2'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                         12'($urandom), 12'($urandom), 12'($urandom));
    endfunction

    function automatic logic [11:0] coord(int v);
        if (v < 0)
            return 12'd0;
        if (v > 4095)
            return 12'd4095;
        return 12'(v);
    endfunction

    function automatic int start_error(int lim);
        int n;
        if ($urandom_range(0, 3) == 0)
            n = int'($urandom_range(0, 2 * lim)) - lim;
        else
            n = int'($urandom_range(0, 200)) - 100;
        return n;
    endfunction

    // next round's error: mostly shrinking, sometimes aligned, now and then growing
    function automatic int next_error(int e, int lo, int hi);
        int n;
        case ($urandom_range(0, 9))
            0:       n = 3 * e + 16;
            1, 2:    n = int'($urandom_range(0, 8)) - 4;
            default: n = e * int'($urandom_range(10, 140)) / 100;
        endcase
        if ($urandom_range(0, 3) == 0)
            n = -n;
        if (n < lo)
            n = lo;
        if (n > hi)
            n = hi;
        return n;
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [IN_TDATA_W-1:0] data);
        int gap;
        gap = (!steady_send && $urandom_range(0, 3) == 0) ? gap_length() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic start_task(input logic [1:0] mode, input logic [7:0] color,
                              input logic [15:0] speed, input logic [15:0] period);
        send_item(CMD_START, pack_item(mode, color, speed, period,
                                       12'($urandom), 12'($urandom), 12'($urandom)));
    endtask

    task automatic measure(input logic [11:0] mx, input logic [11:0] my,
                           input logic [11:0] mz);
        send_item(CMD_MEASURE, pack_item(2'($urandom), 8'($urandom), 16'($urandom),
                                         16'($urandom), mx, my, mz));
    endtask

    task automatic tick();
        send_item(CMD_TICK, random_item());
    endtask

    // caller lowers cfg_valid after the last write of a batch
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_TRAY_X:  guide_tray_x  = int'(v);
            CFG_TRAY_Y:  guide_tray_y  = int'(v);
            CFG_CALIB_X: guide_calib_x = int'(v);
            CFG_CALIB_Y: guide_calib_y = int'(v);
            default:
            begin
            end
        endcase
    endtask

    // hold the sender until every owed result is out, then let the pipe drain
    task automatic settle();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (results_due != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // result side back pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!steady_recv && $urandom_range(0, 4) == 0)
                stall_left <= gap_length();
        end
    end

    // watchdog: too long without any accepted item
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int phase, goal, mode, rounds, nt, ex, ey, ez, tx, ty;
        int v_tx, v_ty, v_cx, v_cy, v_tol, v_ztol, v_rounds, v_timeout;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle block ignores ticks, measurements, unknown commands and modes
        tick();
        measure(12'd0, 12'd0, 12'd0);
        send_item(CMD_UNUSED, random_item());
        start_task(TASK_UNUSED, 8'hFF, 16'hFFFF, 16'hFFFF);

        // tray aligned at once; rotation is not looked at
        start_task(MODE_TRAY, 8'hFF, 16'hFFFF, 16'h0000);
        measure(12'd322, 12'd237, 12'h800);

        // ring: extreme corners, a steady round, then divergence
        start_task(MODE_RING, 8'h5A, 16'h0000, 16'hFFFF);
        measure(12'd0, 12'd4095, 12'h7FF);
        measure(12'd0, 12'd4095, 12'h000);
        measure(12'd4095, 12'd240, 12'h000);

        // calibration: all three corrections, rotation only, then aligned
        start_task(MODE_CALIB, 8'h00, 16'h1234, 16'h8001);
        measure(12'd4095, 12'd0, 12'h800);
        measure(12'd320, 12'd240, 12'h7FF);
        measure(12'd318, 12'd242, 12'h003);

        // start while busy aborts the running task
        start_task(MODE_CALIB, 8'hC3, 16'h00FF, 16'hFF00);
        start_task(MODE_TRAY, 8'h3C, 16'hAAAA, 16'h5555);
        measure(12'd330, 12'd240, 12'hFFF);

        // zero rounds finishes on start, then the idle block ignores items
        settle();
        write_reg(CFG_MAX_ROUND, 16'd0);
        write_reg(CFG_TIMEOUT, 16'd0);
        cfg_valid <= 1'b0;
        start_task(MODE_RING, 8'h81, 16'h0001, 16'h0002);
        tick();
        measure(12'd1, 12'd1, 12'd1);

        // timeout on the second tick
        settle();
        write_reg(CFG_MAX_ROUND, 16'd10);
        write_reg(CFG_TIMEOUT, 16'd2);
        cfg_valid <= 1'b0;
        start_task(MODE_TRAY, 8'h00, 16'h0100, 16'h0010);
        tick();
        tick();

        // limit lowered under a running task ends it at the next round
        start_task(MODE_TRAY, 8'h00, 16'h0200, 16'h0020);
        measure(12'd300, 12'd240, 12'd0);
        settle();
        write_reg(CFG_MAX_ROUND, 16'd1);
        cfg_valid <= 1'b0;
        measure(12'd310, 12'd240, 12'd0);

        // random phases, each under its own register setting
        goal = items_sent;
        for (phase = 0; phase < 8; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    v_tx = 0; v_ty = 0; v_cx = 0; v_cy = 0;
                    v_tol = 0; v_ztol = 0; v_rounds = 255; v_timeout = 0;
                end
                1:
                begin
                    v_tx = 4095; v_ty = 4095; v_cx = 4095; v_cy = 4095;
                    v_tol = 255; v_ztol = 255; v_rounds = 0; v_timeout = 65535;
                end
                2:
                begin
                    v_tx = 4095; v_ty = 0; v_cx = 0; v_cy = 4095;
                    v_tol = 255; v_ztol = 255; v_rounds = 255; v_timeout = 65535;
                end
                default:
                begin
                    v_tx = $urandom_range(0, 4095);
                    v_ty = $urandom_range(0, 4095);
                    v_cx = $urandom_range(0, 4095);
                    v_cy = $urandom_range(0, 4095);
                    v_tol = $urandom_range(0, 40);
                    v_ztol = $urandom_range(0, 40);
                    v_rounds = $urandom_range(1, 12);
                    v_timeout = $urandom_range(0, 1) ? $urandom_range(1, 8) : 3000;
                end
            endcase
            write_reg(CFG_TRAY_X, 16'(v_tx));
            write_reg(CFG_TRAY_Y, 16'(v_ty));
            write_reg(CFG_CALIB_X, 16'(v_cx));
            write_reg(CFG_CALIB_Y, 16'(v_cy));
            write_reg(CFG_TOL_PX, 16'(v_tol));
            write_reg(CFG_Z_TOL, 16'(v_ztol));
            write_reg(CFG_MAX_ROUND, 16'(v_rounds));
            write_reg(CFG_TIMEOUT, 16'(v_timeout));
            cfg_valid   <= 1'b0;
            steady_send <= (phase == 3);
            steady_recv <= (phase == 3 || phase == 6);
            goal += (phase == 1) ? 16 : 36;

            // tasks, now and then of an unknown mode, with converging, aligning or diverging errors
            while (items_sent < goal)
            begin
                mode = ($urandom_range(0, 9) == 0) ? int'(TASK_UNUSED)
                                                   : int'($urandom_range(0, 2));
                start_task(2'(mode), 8'($urandom), 16'($urandom), 16'($urandom));
                tx = (mode == MODE_CALIB) ? guide_calib_x : guide_tray_x;
                ty = (mode == MODE_CALIB) ? guide_calib_y : guide_tray_y;
                ex = start_error(4095);
                ey = start_error(4095);
                ez = start_error(2047);
                rounds = $urandom_range(1, 14);
                repeat (rounds)
                begin
                    nt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
                    repeat (nt) tick();
                    // occasional noise item of any command
                    if ($urandom_range(0, 11) == 0)
                        send_item(2'($urandom_range(0, 3)), random_item());
                    measure(coord(tx - ex), coord(ty - ey), 12'(ez));
                    ex = next_error(ex, -4095, 4095);
                    ey = next_error(ey, -4095, 4095);
                    ez = next_error(ez, -2048, 2047);
                end
            end
        end

        settle();
        if (mismatch_count == 0 && results_due == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> sim.f
hdl/vas_pkg.sv
hdl/vas_front.sv
hdl/vas_queue.sv
hdl/vas_back.sv
hdl/visual_alignment_supervisor.sv
test/alignment_result_checker.sv
test/visual_alignment_supervisor_tb.sv
